// ===== sv/abm_pkg.sv =====
// Shared constants, operator codes and payload types of the alpha blend unit.
// No dependencies; every other file refers to this package by scoped names.
package abm_pkg;

    localparam int ALPHA_W   = 8;
    localparam int MODE_W    = 6;
    localparam int CFG_IDX_W = 2;

    // Restoring divider: quotient bits per stage and the stage count
    localparam int DIV_NUM_W  = 18;
    localparam int DIV_DEN_W  = 8;
    localparam int DIV_REM_W  = DIV_DEN_W + 1;
    localparam int DIV_STEP   = 3;
    localparam int DIV_STAGES = DIV_NUM_W / DIV_STEP;

    // Signed width of intermediate results before clamping
    localparam int CALC_W = 19;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_HIGH = 2'd2;

    localparam logic [MODE_W-1:0]  BLEND_MODE_RST = 6'd0;
    localparam logic [ALPHA_W-1:0] CLAMP_LOW_RST  = 8'd16;
    localparam logic [ALPHA_W-1:0] CLAMP_HIGH_RST = 8'd235;

    // Operator codes
    localparam logic [MODE_W-1:0] MODE_ADDITIVE     = 6'd0;
    localparam logic [MODE_W-1:0] MODE_SUBTRACTIVE  = 6'd1;
    localparam logic [MODE_W-1:0] MODE_MULTIPLY     = 6'd2;
    localparam logic [MODE_W-1:0] MODE_DIVIDE       = 6'd3;
    localparam logic [MODE_W-1:0] MODE_LIGHTEN      = 6'd4;
    localparam logic [MODE_W-1:0] MODE_HARDLIGHT    = 6'd5;
    localparam logic [MODE_W-1:0] MODE_DIFFERENCE   = 6'd6;
    localparam logic [MODE_W-1:0] MODE_DIFF_NEGATE  = 6'd7;
    localparam logic [MODE_W-1:0] MODE_EXCLUSIVE    = 6'd8;
    localparam logic [MODE_W-1:0] MODE_BASE         = 6'd9;
    localparam logic [MODE_W-1:0] MODE_FREEZE       = 6'd10;
    localparam logic [MODE_W-1:0] MODE_UNFREEZE     = 6'd11;
    localparam logic [MODE_W-1:0] MODE_REL_ADD      = 6'd12;
    localparam logic [MODE_W-1:0] MODE_REL_SUB      = 6'd13;
    localparam logic [MODE_W-1:0] MODE_MAX_SEL      = 6'd14;
    localparam logic [MODE_W-1:0] MODE_MIN_SEL      = 6'd15;
    localparam logic [MODE_W-1:0] MODE_REL_LUMA_ADD = 6'd16;
    localparam logic [MODE_W-1:0] MODE_REL_LUMA_SUB = 6'd17;
    localparam logic [MODE_W-1:0] MODE_MIN_SUBSEL   = 6'd18;
    localparam logic [MODE_W-1:0] MODE_MAX_SUBSEL   = 6'd19;
    localparam logic [MODE_W-1:0] MODE_ADD_SUBSEL   = 6'd20;
    localparam logic [MODE_W-1:0] MODE_ADD_AVERAGE  = 6'd21;
    localparam logic [MODE_W-1:0] MODE_EXP1         = 6'd22;
    localparam logic [MODE_W-1:0] MODE_EXP2         = 6'd23;
    localparam logic [MODE_W-1:0] MODE_EXP3         = 6'd24;
    localparam logic [MODE_W-1:0] MODE_MULTISUB     = 6'd25;
    localparam logic [MODE_W-1:0] MODE_SOFTBURN     = 6'd26;
    localparam logic [MODE_W-1:0] MODE_INV_BURN     = 6'd27;
    localparam logic [MODE_W-1:0] MODE_DODGE        = 6'd28;
    localparam logic [MODE_W-1:0] MODE_DIST_ADD     = 6'd29;
    localparam logic [MODE_W-1:0] MODE_DIST_SUB     = 6'd30;
    localparam logic [MODE_W-1:0] MODE_EXP4         = 6'd31;
    localparam logic [MODE_W-1:0] MODE_NEG_DIV      = 6'd32;

    typedef struct packed {
        logic [ALPHA_W-1:0] a;
        logic [ALPHA_W-1:0] b;
    } pair_t;

    // Carried alongside the second divider pass
    typedef struct packed {
        logic [ALPHA_W-1:0] a;
        logic [ALPHA_W-1:0] b;
        logic [16:0]        q0;
        logic [15:0]        q1;
        logic               qz;
    } fin_side_t;

endpackage

// ===== sv/abm_if.sv =====
// Stream and configuration channel interfaces of the alpha blend unit.
// Depends on abm_pkg for field widths.
interface abm_in_if;
    logic                        valid;
    logic                        ready;
    logic [abm_pkg::ALPHA_W-1:0] alpha_a;
    logic [abm_pkg::ALPHA_W-1:0] alpha_b;
    modport source (output valid, output alpha_a, output alpha_b, input ready);
    modport sink   (input valid, input alpha_a, input alpha_b, output ready);
endinterface

interface abm_out_if;
    logic                        valid;
    logic                        ready;
    logic [abm_pkg::ALPHA_W-1:0] alpha_out;
    modport source (output valid, output alpha_out, input ready);
    modport sink   (input valid, input alpha_out, output ready);
endinterface

interface abm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [abm_pkg::CFG_IDX_W-1:0] index;
    logic [abm_pkg::ALPHA_W-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/abm_prep.sv =====
// Front stage: selects multiplier operands and divisors per operator.
// Depends on abm_pkg.
module abm_prep (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  abm_pkg::pair_t                               in_pair,
    input  logic [abm_pkg::MODE_W-1:0]                   mode,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic [1:0][abm_pkg::DIV_NUM_W-1:0]           out_num,
    output logic [1:0][abm_pkg::DIV_DEN_W-1:0]           out_den,
    output abm_pkg::pair_t                               out_side
);

    logic                                valid_reg;
    logic [1:0][abm_pkg::DIV_NUM_W-1:0]  num_reg, num_next;
    logic [1:0][abm_pkg::DIV_DEN_W-1:0]  den_reg, den_next;
    abm_pkg::pair_t                      side_reg;
    logic [8:0]                          x0, y0, x1, y1;
    logic [7:0]                          a, b;

    assign in_ready = !valid_reg || out_ready;
    assign a        = in_pair.a;
    assign b        = in_pair.b;

    always_comb
    begin
        x0 = {1'b0, a};
        y0 = {1'b0, b};
        x1 = 9'd255 - {1'b0, a};
        y1 = 9'd255 - {1'b0, b};
        den_next[0] = 8'd1;
        den_next[1] = 8'd1;
        unique case (mode)
            abm_pkg::MODE_DIVIDE:
            begin
                y0 = 9'd1;
                den_next[0] = (b > 8'd1) ? b : 8'd1;
            end
            abm_pkg::MODE_FREEZE:
            begin
                x0 = 9'd255 - {1'b0, a};
                y0 = x0;
                den_next[0] = (b != 8'd0) ? b : 8'd1;
            end
            abm_pkg::MODE_UNFREEZE:
            begin
                x0 = 9'd255 - {1'b0, b};
                y0 = x0;
                den_next[0] = (a != 8'd0) ? a : 8'd1;
            end
            abm_pkg::MODE_MULTISUB:
            begin
                y0 = 9'd1;
                den_next[0] = (b != 8'd255) ? 8'd255 - b : 8'd1;
            end
            abm_pkg::MODE_EXP4:
            begin
                x0 = 9'd256 - {1'b0, a};
                y0 = x0;
                den_next[0] = (a != 8'd0) ? a : 8'd1;
                x1 = 9'd256 - {1'b0, b};
                y1 = x1;
                den_next[1] = (b != 8'd0) ? b : 8'd1;
            end
            abm_pkg::MODE_NEG_DIV:
            begin
                y0 = {1'b0, a};
                den_next[0] = (b != 8'd255) ? 8'd255 - b : 8'd1;
            end
            default:
            begin
                x0 = {1'b0, a};
            end
        endcase
        num_next[0] = x0 * y0;
        num_next[1] = x1 * y1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            side_reg <= in_pair;
        end
    end

    assign out_valid = valid_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

// ===== sv/abm_div_stage.sv =====
// One stage of the restoring divider: DIV_STEP quotient bits per lane.
// Depends on abm_pkg for divider widths.
module abm_div_stage #(
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic [LANES-1:0][abm_pkg::DIV_REM_W-1:0]    in_rem,
    input  logic [LANES-1:0][abm_pkg::DIV_NUM_W-1:0]    in_work,
    input  logic [LANES-1:0][abm_pkg::DIV_DEN_W-1:0]    in_den,
    input  logic [SIDE_W-1:0]                           in_side,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [LANES-1:0][abm_pkg::DIV_REM_W-1:0]    out_rem,
    output logic [LANES-1:0][abm_pkg::DIV_NUM_W-1:0]    out_work,
    output logic [LANES-1:0][abm_pkg::DIV_DEN_W-1:0]    out_den,
    output logic [SIDE_W-1:0]                           out_side
);

    logic                                          valid_reg;
    logic [LANES-1:0][abm_pkg::DIV_REM_W-1:0]      rem_reg, rem_next;
    logic [LANES-1:0][abm_pkg::DIV_NUM_W-1:0]      work_reg, work_next;
    logic [LANES-1:0][abm_pkg::DIV_DEN_W-1:0]      den_reg;
    logic [SIDE_W-1:0]                             side_reg;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        logic [abm_pkg::DIV_REM_W-1:0] r;
        logic [abm_pkg::DIV_NUM_W-1:0] w;
        for (int l = 0; l < LANES; l++)
        begin
            r = in_rem[l];
            w = in_work[l];
            for (int k = 0; k < abm_pkg::DIV_STEP; k++)
            begin
                r = {r[abm_pkg::DIV_REM_W-2:0], w[abm_pkg::DIV_NUM_W-1]};
                w = {w[abm_pkg::DIV_NUM_W-2:0], 1'b0};
                if (r >= {1'b0, in_den[l]})
                begin
                    r    = r - {1'b0, in_den[l]};
                    w[0] = 1'b1;
                end
            end
            rem_next[l]  = r;
            work_next[l] = w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rem_reg  <= rem_next;
            work_reg <= work_next;
            den_reg  <= in_den;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_work  = work_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

// ===== sv/abm_mid.sv =====
// Middle stage: derives the second-pass product and divisor from the
// first-pass quotients. Depends on abm_pkg.
module abm_mid (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0][abm_pkg::DIV_NUM_W-1:0]    in_quo,
    input  abm_pkg::pair_t                        in_side,
    input  logic [abm_pkg::MODE_W-1:0]            mode,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [0:0][abm_pkg::DIV_NUM_W-1:0]    out_num,
    output logic [0:0][abm_pkg::DIV_DEN_W-1:0]    out_den,
    output abm_pkg::fin_side_t                    out_side
);

    logic                               valid_reg;
    logic [abm_pkg::DIV_NUM_W-1:0]      num_reg, num_next;
    logic [abm_pkg::DIV_DEN_W-1:0]      den_reg, den_next;
    abm_pkg::fin_side_t                 side_reg, side_next;
    logic [abm_pkg::DIV_NUM_W-1:0]      q0, q1;
    logic [7:0]                         a, b, p, qv;
    logic [8:0]                         d, mx, my;

    assign in_ready = !valid_reg || out_ready;
    assign a  = in_side.a;
    assign b  = in_side.b;
    assign q0 = in_quo[0];
    assign q1 = in_quo[1];

    always_comb
    begin
        d  = 9'd255 - {1'b0, q1[15:8]} - {1'b0, q0[15:8]};
        p  = (a == 8'd0 || q0 >= 18'd255) ? 8'd0 : 8'd255 - q0[7:0];
        qv = (b == 8'd0 || q1 >= 18'd255) ? 8'd0 : 8'd255 - q1[7:0];
        mx = 9'd0;
        my = 9'd0;
        den_next = 8'd1;
        unique case (mode)
            abm_pkg::MODE_BASE:
            begin
                mx = {1'b0, a};
                my = d;
            end
            abm_pkg::MODE_EXP4:
            begin
                mx = 9'd256 - {1'b0, p};
                my = 9'd256 - {1'b0, b};
                den_next = (qv != 8'd0) ? qv : 8'd1;
            end
            default:
            begin
                mx = 9'd0;
            end
        endcase
        num_next     = mx * my;
        side_next.a  = a;
        side_next.b  = b;
        side_next.q0 = q0[16:0];
        side_next.q1 = q1[15:0];
        side_next.qz = (qv == 8'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            side_reg <= side_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_num[0] = num_reg;
    assign out_den[0] = den_reg;
    assign out_side   = side_reg;

endmodule

// ===== sv/abm_final.sv =====
// Output stage: selects the operator result, clamps, and holds the result.
// Depends on abm_pkg.
module abm_final (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [abm_pkg::DIV_NUM_W-1:0]   in_quo,
    input  abm_pkg::fin_side_t              in_side,
    input  logic [abm_pkg::MODE_W-1:0]      mode,
    input  logic [abm_pkg::ALPHA_W-1:0]     clamp_low,
    input  logic [abm_pkg::ALPHA_W-1:0]     clamp_high,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [abm_pkg::ALPHA_W-1:0]     alpha_out
);

    localparam int CW = abm_pkg::CALC_W;

    logic                       valid_reg;
    logic [7:0]                 alpha_reg, alpha_next;
    logic [7:0]                 a, b, amax, amin, half_sum, diff8;
    logic [16:0]                q0;
    logic [15:0]                q1;
    logic [8:0]                 rel_sub, mm_lo, mm_hi, avg;
    logic signed [CW-1:0]       sa, sb, sq0, sc, sq2, t_add, s7, abs7, neg7;

    function automatic logic [7:0] clampv(input logic signed [CW-1:0] x,
                                          input logic [7:0] lo,
                                          input logic [7:0] hi);
        logic signed [CW-1:0] slo, shi;
        slo = $signed({{(CW-8){1'b0}}, lo});
        shi = $signed({{(CW-8){1'b0}}, hi});
        priority if (x < slo)
            return lo;
        else if (x > shi)
            return hi;
        else
            return x[7:0];
    endfunction

    assign in_ready = !valid_reg || out_ready;
    assign a  = in_side.a;
    assign b  = in_side.b;
    assign q0 = in_side.q0;
    assign q1 = in_side.q1;

    always_comb
    begin
        sa       = $signed({{(CW-8){1'b0}}, a});
        sb       = $signed({{(CW-8){1'b0}}, b});
        sq0      = $signed({2'b00, q0});
        sc       = $signed({{(CW-8){1'b0}}, q0[15:8]});
        sq2      = $signed({{(CW-8){1'b0}}, in_quo[15:8]});
        t_add    = sa + sb + sb - 19'sd255;
        amax     = (a > b) ? a : b;
        amin     = (a > b) ? b : a;
        half_sum = {1'b0, a[7:1]} + {1'b0, b[7:1]};
        diff8    = a - b;
        rel_sub  = {1'b0, a} + 9'd255 - {1'b0, b};
        mm_lo    = {1'b0, amin} + 9'd255 - {1'b0, amax};
        mm_hi    = {1'b0, amax} + 9'd255 - {1'b0, amin};
        avg      = {1'b0, a} + {1'b0, b};
        s7       = 19'sd255 - sa - sb;
        abs7     = (s7 < 0) ? -s7 : s7;
        neg7     = 19'sd255 - abs7;
        unique case (mode)
            abm_pkg::MODE_ADDITIVE,
            abm_pkg::MODE_EXP2:         alpha_next = clampv(t_add, clamp_low, clamp_high);
            abm_pkg::MODE_SUBTRACTIVE:  alpha_next = clampv(sa - sb, clamp_low, clamp_high);
            abm_pkg::MODE_MULTIPLY:     alpha_next = q0[15:8];
            abm_pkg::MODE_DIVIDE,
            abm_pkg::MODE_MULTISUB,
            abm_pkg::MODE_NEG_DIV:      alpha_next = q0[7:0];
            abm_pkg::MODE_LIGHTEN,
            abm_pkg::MODE_MAX_SEL:      alpha_next = amax;
            abm_pkg::MODE_HARDLIGHT:
                alpha_next = (b < 8'd128) ? q0[14:7] : 8'd255 - q1[14:7];
            abm_pkg::MODE_DIFFERENCE:   alpha_next = amax - amin;
            abm_pkg::MODE_DIFF_NEGATE:  alpha_next = neg7[7:0];
            abm_pkg::MODE_EXCLUSIVE:
                alpha_next = clampv(t_add - sc, clamp_low, clamp_high);
            abm_pkg::MODE_BASE:
                alpha_next = clampv(sc + sq2, clamp_low, clamp_high);
            abm_pkg::MODE_FREEZE:
                alpha_next = (b != 8'd0)
                           ? clampv(19'sd255 - sq0, clamp_low, clamp_high) : a;
            abm_pkg::MODE_UNFREEZE:
                alpha_next = (a != 8'd0)
                           ? clampv(19'sd255 - sq0, clamp_low, clamp_high) : a;
            abm_pkg::MODE_REL_ADD:      alpha_next = half_sum;
            abm_pkg::MODE_REL_SUB,
            abm_pkg::MODE_REL_LUMA_SUB: alpha_next = rel_sub[8:1];
            abm_pkg::MODE_MIN_SEL:      alpha_next = amin;
            abm_pkg::MODE_REL_LUMA_ADD:
                alpha_next = clampv($signed({{(CW-8){1'b0}}, half_sum}),
                                    clamp_low, clamp_high);
            abm_pkg::MODE_MIN_SUBSEL:   alpha_next = mm_lo[8:1];
            abm_pkg::MODE_MAX_SUBSEL:   alpha_next = mm_hi[8:1];
            abm_pkg::MODE_ADD_SUBSEL:   alpha_next = (b < a) ? avg[8:1] : a;
            abm_pkg::MODE_ADD_AVERAGE,
            abm_pkg::MODE_DIST_ADD:
                alpha_next = clampv($signed({{(CW-9){1'b0}}, avg}),
                                    clamp_low, clamp_high);
            abm_pkg::MODE_EXP1:
                alpha_next = clampv(t_add >>> 1, clamp_low, clamp_high);
            abm_pkg::MODE_EXP3:         alpha_next = a;
            abm_pkg::MODE_SOFTBURN:
                // both division branches reduce to constant results
                alpha_next = (avg <= 9'd255) ? ((a == 8'd255) ? 8'd255 : 8'd0)
                                             : 8'd255;
            abm_pkg::MODE_INV_BURN:
                alpha_next = clampv((a == 8'd0) ? 19'sd0 : 19'sd255,
                                    clamp_low, clamp_high);
            abm_pkg::MODE_DODGE:        alpha_next = (a == 8'd255) ? 8'd255 : 8'd0;
            abm_pkg::MODE_DIST_SUB:
                alpha_next = clampv($signed({{(CW-8){1'b0}}, diff8}),
                                    clamp_low, clamp_high);
            abm_pkg::MODE_EXP4:
                alpha_next = in_side.qz ? 8'd0 : 8'd255 - in_quo[7:0];
            default:                    alpha_next = a;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            alpha_reg <= alpha_next;
        end
    end

    assign out_valid = valid_reg;
    assign alpha_out = alpha_reg;

endmodule

// ===== sv/alpha_blend_mode_unit.sv =====
// Top level of the alpha blend unit: configuration registers and the pipeline.
// Depends on abm_pkg, abm_if, abm_prep, abm_div_stage, abm_mid and abm_final.
//
// Usage:
//   samples : alpha pairs (alpha_a, alpha_b); a transfer when valid and ready.
//   result  : one blended alpha_out per accepted pair, in arrival order.
//   cfg     : register writes (index 0 blend_mode, 1 clamp_low, 2 clamp_high);
//             always ready, writes to index 3 are dropped. Write only while
//             no pair is in flight.
// Pipeline: one operand stage, six divider stages, one mid stage, six
//   more divider stages and the output register lie between a samples
//   transfer and result valid. Each divider stage retires three quotient bits.
// Throughput: one pair per cycle while result.ready stays high. Every stage
//   holds a valid bit and advances when it is empty or the stage after it
//   advances, so bubbles close up and samples stay ready until the pipeline fills.
// Reset: all valid bits clear, registers return to additive mode with
//   bounds 16..235. When the receiver stalls, the result holds and the
//   pipeline fills up before samples.ready drops.
module alpha_blend_mode_unit (
    input  logic              clk,
    input  logic              rst_n,
    abm_in_if.sink            samples,
    abm_out_if.source         result,
    abm_cfg_if.sink           cfg
);

    localparam int NS         = abm_pkg::DIV_STAGES;
    localparam int PIPE_DEPTH = 2 * NS + 3;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);
    localparam int SIDE1_W    = $bits(abm_pkg::pair_t);
    localparam int SIDE2_W    = $bits(abm_pkg::fin_side_t);

    logic [abm_pkg::MODE_W-1:0]  blend_mode_reg;
    logic [abm_pkg::ALPHA_W-1:0] clamp_low_reg;
    logic [abm_pkg::ALPHA_W-1:0] clamp_high_reg;

    // First divider pass (two lanes)
    logic [NS:0]                                     d1_valid, d1_ready;
    logic [NS:0][1:0][abm_pkg::DIV_REM_W-1:0]        d1_rem;
    logic [NS:0][1:0][abm_pkg::DIV_NUM_W-1:0]        d1_work;
    logic [NS:0][1:0][abm_pkg::DIV_DEN_W-1:0]        d1_den;
    logic [NS:0][SIDE1_W-1:0]                        d1_side;
    abm_pkg::pair_t                                  in_pair, prep_side;

    // Second divider pass (one lane)
    logic [NS:0]                                     d2_valid, d2_ready;
    logic [NS:0][0:0][abm_pkg::DIV_REM_W-1:0]        d2_rem;
    logic [NS:0][0:0][abm_pkg::DIV_NUM_W-1:0]        d2_work;
    logic [NS:0][0:0][abm_pkg::DIV_DEN_W-1:0]        d2_den;
    logic [NS:0][SIDE2_W-1:0]                        d2_side;
    abm_pkg::fin_side_t                              mid_side;

    logic                                            fin_valid;
    logic [PIPE_DEPTH-1:0]                           stage_valid;
    logic [CNT_W-1:0]                                inflight_reg, inflight_next;
    logic                                            in_xfer, out_xfer;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg <= abm_pkg::BLEND_MODE_RST;
            clamp_low_reg  <= abm_pkg::CLAMP_LOW_RST;
            clamp_high_reg <= abm_pkg::CLAMP_HIGH_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                abm_pkg::CFG_BLEND_MODE: blend_mode_reg <= cfg.data[abm_pkg::MODE_W-1:0];
                abm_pkg::CFG_CLAMP_LOW:  clamp_low_reg  <= cfg.data;
                abm_pkg::CFG_CLAMP_HIGH: clamp_high_reg <= cfg.data;
                default:                 blend_mode_reg <= blend_mode_reg;
            endcase
        end
    end

    // Operand stage: products and divisors
    assign in_pair.a = samples.alpha_a;
    assign in_pair.b = samples.alpha_b;

    abm_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .in_pair   (in_pair),
        .mode      (blend_mode_reg),
        .out_valid (d1_valid[0]),
        .out_ready (d1_ready[0]),
        .out_num   (d1_work[0]),
        .out_den   (d1_den[0]),
        .out_side  (prep_side)
    );

    assign d1_rem[0]  = '0;
    assign d1_side[0] = prep_side;

    genvar gi;
    generate
        for (gi = 0; gi < NS; gi++)
        begin : g_div1
            abm_div_stage #(
                .LANES  (2),
                .SIDE_W (SIDE1_W)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (d1_valid[gi]),
                .in_ready  (d1_ready[gi]),
                .in_rem    (d1_rem[gi]),
                .in_work   (d1_work[gi]),
                .in_den    (d1_den[gi]),
                .in_side   (d1_side[gi]),
                .out_valid (d1_valid[gi+1]),
                .out_ready (d1_ready[gi+1]),
                .out_rem   (d1_rem[gi+1]),
                .out_work  (d1_work[gi+1]),
                .out_den   (d1_den[gi+1]),
                .out_side  (d1_side[gi+1])
            );
        end
    endgenerate

    // Mid stage: set up the second quotient
    abm_mid u_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d1_valid[NS]),
        .in_ready  (d1_ready[NS]),
        .in_quo    (d1_work[NS]),
        .in_side   (abm_pkg::pair_t'(d1_side[NS])),
        .mode      (blend_mode_reg),
        .out_valid (d2_valid[0]),
        .out_ready (d2_ready[0]),
        .out_num   (d2_work[0]),
        .out_den   (d2_den[0]),
        .out_side  (mid_side)
    );

    assign d2_rem[0]  = '0;
    assign d2_side[0] = mid_side;

    generate
        for (gi = 0; gi < NS; gi++)
        begin : g_div2
            abm_div_stage #(
                .LANES  (1),
                .SIDE_W (SIDE2_W)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (d2_valid[gi]),
                .in_ready  (d2_ready[gi]),
                .in_rem    (d2_rem[gi]),
                .in_work   (d2_work[gi]),
                .in_den    (d2_den[gi]),
                .in_side   (d2_side[gi]),
                .out_valid (d2_valid[gi+1]),
                .out_ready (d2_ready[gi+1]),
                .out_rem   (d2_rem[gi+1]),
                .out_work  (d2_work[gi+1]),
                .out_den   (d2_den[gi+1]),
                .out_side  (d2_side[gi+1])
            );
        end
    endgenerate

    // Output stage: select, clamp and hold the result
    abm_final u_final (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (d2_valid[NS]),
        .in_ready   (d2_ready[NS]),
        .in_quo     (d2_work[NS][0]),
        .in_side    (abm_pkg::fin_side_t'(d2_side[NS])),
        .mode       (blend_mode_reg),
        .clamp_low  (clamp_low_reg),
        .clamp_high (clamp_high_reg),
        .out_valid  (fin_valid),
        .out_ready  (result.ready),
        .alpha_out  (result.alpha_out)
    );

    assign result.valid = fin_valid;

    // Occupancy tracking for the checks below
    assign stage_valid = {fin_valid, d2_valid, d1_valid};
    assign in_xfer     = samples.valid && samples.ready;
    assign out_xfer    = result.valid && result.ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_xfer && !out_xfer)
            inflight_next = inflight_reg + 1'b1;
        else if (out_xfer && !in_xfer)
            inflight_next = inflight_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    // Every transfer in flight sits in exactly one stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(stage_valid) == 32'(inflight_reg))
        else $error("pipeline occupancy does not match transfers in flight");

    // An empty operand stage never back-pressures the source
    assert property (@(posedge clk) disable iff (!rst_n)
        !d1_valid[0] |-> samples.ready)
        else $error("samples stalled with empty operand stage");

    // Divisors reaching the dividers are never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        d1_valid[0] |-> (d1_den[0][0] != '0 && d1_den[0][1] != '0))
        else $error("zero divisor in first divider pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        d2_valid[0] |-> d2_den[0][0] != '0)
        else $error("zero divisor in second divider pass");

endmodule

// ===== tb/sv/tb_alpha_blend_mode_unit.sv =====
// Self-checking bench for the alpha blend unit: random and directed pairs under every operator.
// Depends on abm_pkg, abm_if and alpha_blend_mode_unit.
module tb_alpha_blend_mode_unit;

    typedef struct {
        logic [abm_pkg::ALPHA_W-1:0] a;
        logic [abm_pkg::ALPHA_W-1:0] b;
    } pix_t;

    localparam int LATENCY   = 15;
    localparam int MAX_CYCLE = 400000;

    logic clk;
    logic rst_n;

    abm_in_if  samples();
    abm_out_if result();
    abm_cfg_if cfg();

    alpha_blend_mode_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples.sink),
        .result  (result.source),
        .cfg     (cfg.sink)
    );

    // Local copy of the configuration registers
    logic [abm_pkg::MODE_W-1:0]  cur_mode;
    logic [abm_pkg::ALPHA_W-1:0] cur_lo;
    logic [abm_pkg::ALPHA_W-1:0] cur_hi;

    pix_t                        pending_pix[$];
    logic [abm_pkg::ALPHA_W-1:0] expected_alpha[$];

    int  cycle_cnt;
    int  error_cnt;
    int  pix_sent;
    int  pix_checked;
    int  modes_seen;
    bit  quiet_idle;   // no idling on either side
    bit  hold_off_req; // ask the receiver for a long stall
    int  hold_left;
    bit  hold_active;
    bit  hold_done;    // the long stall runs only once after reset

    always #5 clk = ~clk;

    function automatic int clampv(int x);
        if (x < int'(cur_lo))
            return int'(cur_lo);
        if (x > int'(cur_hi))
            return int'(cur_hi);
        return x;
    endfunction

    function automatic int diffabs(int x, int y);
        return x > y ? x - y : y - x;
    endfunction

    // Blend one pair under the current operator and bounds
    function automatic logic [abm_pkg::ALPHA_W-1:0] blend_alpha(
        logic [abm_pkg::ALPHA_W-1:0] av,
        logic [abm_pkg::ALPHA_W-1:0] bv);
        int a, b, c, d, p, q, r, s;
        a = av;
        b = bv;
        case (cur_mode)
            abm_pkg::MODE_ADDITIVE:     r = clampv(a + 2 * b - 255);
            abm_pkg::MODE_SUBTRACTIVE:  r = clampv(a - b);
            abm_pkg::MODE_MULTIPLY:     r = (a * b) >> 8;
            abm_pkg::MODE_DIVIDE:       r = b > 1 ? a / b : a;
            abm_pkg::MODE_LIGHTEN:      r = a > b ? a : b;
            abm_pkg::MODE_HARDLIGHT:    r = b < 128 ? (a * b) >> 7
                                            : 255 - (((255 - b) * (255 - a)) >> 7);
            abm_pkg::MODE_DIFFERENCE:   r = diffabs(a, b);
            abm_pkg::MODE_DIFF_NEGATE:  r = 255 - diffabs(255 - a, b);
            abm_pkg::MODE_EXCLUSIVE:    r = clampv(a + 2 * b - 255 - ((a * b) >> 8));
            abm_pkg::MODE_BASE:
            begin
                c = (a * b) >> 8;
                d = 255 - (((255 - a) * (255 - b)) >> 8) - c;
                r = clampv(c + ((a * d) >> 8));
            end
            abm_pkg::MODE_FREEZE:
                r = b > 0 ? clampv(255 - ((255 - a) * (255 - a)) / b) : a;
            abm_pkg::MODE_UNFREEZE:
                r = a > 0 ? clampv(255 - ((255 - b) * (255 - b)) / a) : a;
            abm_pkg::MODE_REL_ADD:      r = (a >> 1) + (b >> 1);
            abm_pkg::MODE_REL_SUB:      r = (a - b + 255) >> 1;
            abm_pkg::MODE_MAX_SEL:      r = b > a ? b : a;
            abm_pkg::MODE_MIN_SEL:      r = b < a ? b : a;
            abm_pkg::MODE_REL_LUMA_ADD: r = clampv((a >> 1) + (b >> 1));
            abm_pkg::MODE_REL_LUMA_SUB: r = (a - b + 255) >> 1;
            abm_pkg::MODE_MIN_SUBSEL:
                r = b < a ? (b - a + 255) >> 1 : (a - b + 255) >> 1;
            abm_pkg::MODE_MAX_SUBSEL:
                r = b > a ? (b - a + 255) >> 1 : (a - b + 255) >> 1;
            abm_pkg::MODE_ADD_SUBSEL:   r = b < a ? (a + b) >> 1 : a;
            abm_pkg::MODE_ADD_AVERAGE:  r = clampv(a + b);
            abm_pkg::MODE_EXP1:
            begin
                s = a + 2 * b - 255;
                r = clampv(s >= 0 ? s / 2 : -((1 - s) / 2));
            end
            abm_pkg::MODE_EXP2:         r = clampv(a + 2 * b - 255);
            abm_pkg::MODE_EXP3:         r = a;
            abm_pkg::MODE_MULTISUB:     r = b < 255 ? a / (255 - b) : a;
            abm_pkg::MODE_SOFTBURN:
            begin
                if (a + b <= 255)
                    r = a == 255 ? 255 : (b >> 7) / (256 - a);
                else
                    r = 255 - ((255 - a) >> 7) / (b < 1 ? 255 : b);
            end
            abm_pkg::MODE_INV_BURN:     r = clampv(a < 1 ? 0 : 255);
            abm_pkg::MODE_DODGE:        r = a >= 255 ? 255 : 0;
            abm_pkg::MODE_DIST_ADD:     r = clampv(a + b);
            abm_pkg::MODE_DIST_SUB:     r = clampv((a - b) & 255);
            abm_pkg::MODE_EXP4:
            begin
                p = a < 1 ? 0 : 255 - ((256 - a) * (256 - a)) / a;
                if (p < 1)
                    p = 0;
                q = b < 1 ? 0 : 255 - ((256 - b) * (256 - b)) / b;
                r = q < 1 ? 0 : 255 - ((256 - p) * (256 - b)) / q;
            end
            abm_pkg::MODE_NEG_DIV:
            begin
                c = 255 - b;
                if (c == 0)
                    c = 1;
                r = (a * a) / c;
            end
            default:                    r = a;
        endcase
        return r[abm_pkg::ALPHA_W-1:0];
    endfunction

    // Driver: offer the oldest pending pair, idle now and then
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples.valid   <= 1'b0;
            samples.alpha_a <= '0;
            samples.alpha_b <= '0;
        end
        else
        begin
            if (samples.valid && samples.ready)
            begin
                expected_alpha.push_back(blend_alpha(samples.alpha_a, samples.alpha_b));
                pix_sent++;
            end
            if ((!samples.valid || samples.ready) )
            begin
                if (pending_pix.size() > 0 && (quiet_idle || $urandom_range(99) >= 32))
                begin
                    samples.valid   <= 1'b1;
                    samples.alpha_a <= pending_pix[0].a;
                    samples.alpha_b <= pending_pix[0].b;
                    void'(pending_pix.pop_front());
                end
                else
                    samples.valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result transfer with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            hold_left    <= 0;
            hold_active  <= 1'b0;
            hold_done    <= 1'b0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_alpha.size() == 0)
                begin
                    $error("alpha_out: unexpected result %0d", result.alpha_out);
                    error_cnt++;
                end
                else
                begin
                    if (result.alpha_out !== expected_alpha[0])
                    begin
                        $error("alpha_out: expected %0d actual %0d",
                               expected_alpha[0], result.alpha_out);
                        error_cnt++;
                    end
                    void'(expected_alpha.pop_front());
                    pix_checked++;
                end
            end
            // Hold off the receiver for one long stretch once asked
            if (hold_off_req && !hold_active && !hold_done)
            begin
                hold_active  <= 1'b1;
                hold_done    <= 1'b1;
                hold_left    <= 200;
                result.ready <= 1'b0;
            end
            else if (hold_active)
            begin
                if (hold_left == 1)
                    hold_active <= 1'b0;
                hold_left    <= hold_left - 1;
                result.ready <= 1'b0;
            end
            else
                result.ready <= quiet_idle || $urandom_range(99) >= 32;
        end
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > MAX_CYCLE)
        begin
            $display("tb_alpha_blend_mode_unit: FAIL");
            $finish;
        end
    end

    // Wait for the pipeline to drain, plus slack for any trailing work
    task automatic drain();
        while (pending_pix.size() > 0 || samples.valid || expected_alpha.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_reg(logic [abm_pkg::CFG_IDX_W-1:0] idx,
                             logic [abm_pkg::ALPHA_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        // Mirror the write; index 3 is dropped
        if (idx == abm_pkg::CFG_BLEND_MODE)
            cur_mode = val[abm_pkg::MODE_W-1:0];
        else if (idx == abm_pkg::CFG_CLAMP_LOW)
            cur_lo = val;
        else if (idx == abm_pkg::CFG_CLAMP_HIGH)
            cur_hi = val;
    endtask

    task automatic push_pix(logic [abm_pkg::ALPHA_W-1:0] a, logic [abm_pkg::ALPHA_W-1:0] b);
        pix_t p;
        p.a = a;
        p.b = b;
        pending_pix.push_back(p);
    endtask

    // Well-formed random pair, with a bias toward edge values
    task automatic push_random();
        logic [abm_pkg::ALPHA_W-1:0] a, b;
        a = abm_pkg::ALPHA_W'($urandom_range(255));
        b = abm_pkg::ALPHA_W'($urandom_range(255));
        case ($urandom_range(7))
            0: a = $urandom_range(1) ? 8'd255 : 8'd0;
            1: b = $urandom_range(1) ? 8'd255 : 8'd0;
            2: b = $urandom_range(1) ? 8'd127 : 8'd128;
            3: b = a;
            default: ;
        endcase
        push_pix(a, b);
    endtask

    initial
    begin
        logic [abm_pkg::ALPHA_W-1:0] lo, hi;
        int n;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data  = '0;
        cur_mode = abm_pkg::BLEND_MODE_RST;
        cur_lo   = abm_pkg::CLAMP_LOW_RST;
        cur_hi   = abm_pkg::CLAMP_HIGH_RST;
        cycle_cnt = 0;
        error_cnt = 0;
        pix_sent = 0;
        pix_checked = 0;
        modes_seen = 0;
        quiet_idle = 1'b0;
        hold_off_req = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset bounds in additive mode, field extremes
        push_pix(8'd0, 8'd0);
        push_pix(8'd255, 8'd255);
        push_pix(8'd255, 8'd0);
        push_pix(8'd0, 8'd255);
        push_pix(8'd128, 8'd127);
        push_pix(8'd1, 8'd1);
        drain();
        // Dropped write, then degenerate bounds with low above high
        write_reg(2'd3, 8'hA5);
        write_reg(abm_pkg::CFG_CLAMP_LOW, 8'd200);
        write_reg(abm_pkg::CFG_CLAMP_HIGH, 8'd50);
        write_reg(abm_pkg::CFG_BLEND_MODE, abm_pkg::ALPHA_W'(abm_pkg::MODE_SUBTRACTIVE));
        push_pix(8'd255, 8'd0);
        push_pix(8'd100, 8'd0);
        push_pix(8'd0, 8'd255);
        drain();
        // Unused operator code passes A through
        write_reg(abm_pkg::CFG_BLEND_MODE, 8'd63);
        push_pix(8'd77, 8'd200);
        push_pix(8'd255, 8'd1);
        drain();

        // Random: sweep operators and bounds, a few dozen pairs each
        for (int ph = 0; ph < 40; ph++)
        begin
            if (ph < 33)
                write_reg(abm_pkg::CFG_BLEND_MODE, abm_pkg::ALPHA_W'(ph));
            else
                write_reg(abm_pkg::CFG_BLEND_MODE,
                          abm_pkg::ALPHA_W'($urandom_range(63)));
            modes_seen++;
            case (ph % 4)
                0: begin lo = 8'd0;   hi = 8'd255; end
                1: begin lo = abm_pkg::CLAMP_LOW_RST; hi = abm_pkg::CLAMP_HIGH_RST; end
                2:
                begin
                    lo = abm_pkg::ALPHA_W'($urandom_range(255));
                    hi = abm_pkg::ALPHA_W'($urandom_range(255));
                end
                default: begin lo = 8'd255; hi = 8'd0; end
            endcase
            write_reg(abm_pkg::CFG_CLAMP_LOW, lo);
            write_reg(abm_pkg::CFG_CLAMP_HIGH, hi);
            quiet_idle = (ph == 7);
            hold_off_req = (ph == 12);
            n = $urandom_range(20, 35);
            for (int i = 0; i < n; i++)
                push_random();
            drain();
            hold_off_req = 1'b0;
        end
        quiet_idle = 1'b0;

        $display("Checked %0d of %0d pairs across %0d operator/bound phases.",
                 pix_checked, pix_sent, modes_seen);
        if (error_cnt == 0)
            $display("tb_alpha_blend_mode_unit: PASS");
        else
            $display("tb_alpha_blend_mode_unit: FAIL");
        $finish;
    end
endmodule
